FILE: hdl/raf_pkg.sv
// ----------------------------------------------------------------------------
// raf_pkg
// shared widths, types and constants of the running average filter
// ----------------------------------------------------------------------------
package raf_pkg;

  // sample and result width
  localparam int unsigned DATA_W       = 32;
  // deepest window the ring store can hold
  localparam int unsigned MAX_WINDOW   = 32;
  // window size register
  localparam int unsigned WIN_W        = 6;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(20);

  // ring slot index, entry count and running sum widths
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int unsigned SUM_W  = DATA_W + $clog2(MAX_WINDOW);
  // divider step counter
  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_DIVIDE = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_UNUSED = 5'b10000
  } raf_state_e;

endpackage

FILE: hdl/raf_ram.sv
// ----------------------------------------------------------------------------
// raf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module raf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/raf_divider.sv
// ----------------------------------------------------------------------------
// raf_divider
// iterative signed sum by unsigned count division, one quotient bit a cycle
// ----------------------------------------------------------------------------
module raf_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [raf_pkg::SUM_W-1:0]     dividend_i,
  input  logic [raf_pkg::CNT_W-1:0]            divisor_i,
  output raf_pkg::div_status_t                 status_o,
  output logic [raf_pkg::DATA_W-1:0]           quotient_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [raf_pkg::ITER_W-1:0]      iter_q, iter_d;
  logic                            neg_q, neg_d;
  logic [raf_pkg::CNT_W-1:0]       div_q, div_d;
  logic [raf_pkg::CNT_W-1:0]       rem_q, rem_d;
  logic [raf_pkg::SUM_W-1:0]       quo_q, quo_d;

  logic [raf_pkg::CNT_W:0]         rem_sh;
  logic [raf_pkg::CNT_W:0]         div_ext;
  logic [raf_pkg::CNT_W:0]         rem_sub;
  logic                            ge;
  logic [raf_pkg::SUM_W-1:0]       mag_in;
  logic [raf_pkg::SUM_W-1:0]       result;

  // shift in next dividend bit, trial subtract
  assign rem_sh  = {rem_q, quo_q[raf_pkg::SUM_W-1]};
  assign div_ext = {1'b0, div_q};
  assign ge      = (rem_sh >= div_ext);
  assign rem_sub = rem_sh - div_ext;
  assign mag_in  = dividend_i[raf_pkg::SUM_W-1] ? -dividend_i : dividend_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    neg_d  = neg_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = raf_pkg::ITER_W'(raf_pkg::SUM_W);
      neg_d  = dividend_i[raf_pkg::SUM_W-1];
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = mag_in;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[raf_pkg::CNT_W-1:0] : rem_sh[raf_pkg::CNT_W-1:0];
      quo_d  = {quo_q[raf_pkg::SUM_W-2:0], ge};
      iter_d = iter_q - raf_pkg::ITER_W'(1);
      if (iter_q == raf_pkg::ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign result        = neg_q ? -quo_q : quo_q;
  assign quotient_o    = result[raf_pkg::DATA_W-1:0];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

FILE: hdl/running_average_filter.sv
// ----------------------------------------------------------------------------
// running_average_filter
// boxcar moving average over the most recent window_size signed samples
// ----------------------------------------------------------------------------
// flow: ring read, sum update, the bit-serial steps of the restoring divider,
//   then the output load; no new input is taken until the sequencer is
//   idle again, once the result has been loaded into the output register
// reset: ring entries read as zero (valid bits cleared), sum, slot and count
//   zero, window 20; a window_size write clears the same state at once
// ----------------------------------------------------------------------------
module running_average_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           window_size_we_i,
  input  logic [raf_pkg::WIN_W-1:0]      window_size_i,
  // input item
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [raf_pkg::DATA_W-1:0] sample_i,
  // result item
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [raf_pkg::DATA_W-1:0] average_o
);

  raf_pkg::raf_state_e                  state_q, state_d;

  // configuration and filter state
  logic [raf_pkg::WIN_W-1:0]            window_q;
  logic [raf_pkg::MAX_WINDOW-1:0]       valid_q;
  logic signed [raf_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic [raf_pkg::SLOT_W-1:0]           slot_q;
  logic [raf_pkg::CNT_W-1:0]            count_q, count_d;

  // per item registers
  logic [raf_pkg::SLOT_W-1:0]           cur_slot_q;
  logic signed [raf_pkg::DATA_W-1:0]    sample_q;

  // output register
  logic                                 out_valid_q;
  logic signed [raf_pkg::DATA_W-1:0]    average_q;

  // effective window, zero maps to one and oversize clamps to the maximum
  logic [raf_pkg::CMP_W-1:0]            win_ext;
  logic [raf_pkg::CNT_W-1:0]            eff_win;
  logic [raf_pkg::CNT_W-1:0]            slot_ext;
  logic [raf_pkg::CNT_W-1:0]            cur_ext;
  logic [raf_pkg::CNT_W-1:0]            next_ext;
  logic [raf_pkg::SLOT_W-1:0]           cur_slot;

  logic                                 in_accept;
  logic                                 out_free;
  logic                                 do_update;
  logic signed [raf_pkg::DATA_W-1:0]    old_raw;
  logic signed [raf_pkg::DATA_W-1:0]    old_sample;
  logic signed [raf_pkg::SUM_W-1:0]     old_ext;
  logic signed [raf_pkg::SUM_W-1:0]     new_ext;

  raf_pkg::div_status_t                 div_status;
  logic [raf_pkg::DATA_W-1:0]           quotient;

  assign win_ext = raf_pkg::CMP_W'(window_q);

  always_comb begin
    priority if (window_q == '0) begin
      eff_win = raf_pkg::CNT_W'(1);
    end else if (win_ext > raf_pkg::CMP_W'(raf_pkg::MAX_WINDOW)) begin
      eff_win = raf_pkg::CNT_W'(raf_pkg::MAX_WINDOW);
    end else begin
      eff_win = raf_pkg::CNT_W'(win_ext);
    end
  end

  // slot the incoming item replaces, wrapped into the window
  assign slot_ext = raf_pkg::CNT_W'(slot_q);
  assign cur_slot = (slot_ext >= eff_win) ? '0 : slot_q;
  assign cur_ext  = raf_pkg::CNT_W'(cur_slot_q);
  assign next_ext = cur_ext + raf_pkg::CNT_W'(1);

  assign in_stall_o = (state_q != raf_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign do_update  = (state_q == raf_pkg::S_UPDATE);

  // ring store, one write and one registered read per cycle
  raf_ram #(
    .WIDTH (raf_pkg::DATA_W),
    .DEPTH (raf_pkg::MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (do_update),
    .waddr_i (cur_slot_q),
    .wdata_i (sample_q),
    .raddr_i (cur_slot),
    .rdata_o (old_raw)
  );

  // entries never written since the last clear read as zero
  assign old_sample = valid_q[cur_slot_q] ? old_raw : '0;
  assign old_ext    = raf_pkg::SUM_W'(old_sample);
  assign new_ext    = raf_pkg::SUM_W'(sample_q);
  assign sum_d      = sum_q - old_ext + new_ext;
  assign count_d    = (count_q < eff_win) ? count_q + raf_pkg::CNT_W'(1) : count_q;

  // divider: running sum over the updated entry count
  raf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_update),
    .dividend_i (sum_d),
    .divisor_i  (count_d),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      raf_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = raf_pkg::S_UPDATE;
        end
      end
      raf_pkg::S_UPDATE: begin
        state_d = raf_pkg::S_DIVIDE;
      end
      raf_pkg::S_DIVIDE: begin
        if (div_status.done) begin
          state_d = out_free ? raf_pkg::S_IDLE : raf_pkg::S_DRAIN;
        end
      end
      raf_pkg::S_DRAIN: begin
        if (out_free) begin
          state_d = raf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = raf_pkg::S_IDLE;
      end
    endcase
  end

  // load the output register when the quotient is ready and the slot is free
  logic load_out;
  assign load_out = out_free &&
                    (((state_q == raf_pkg::S_DIVIDE) && div_status.done) ||
                     (state_q == raf_pkg::S_DRAIN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= raf_pkg::S_IDLE;
      window_q    <= raf_pkg::WINDOW_RESET;
      valid_q     <= '0;
      sum_q       <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (window_size_we_i) begin
        // any window write restarts warm-up
        window_q <= window_size_i;
        valid_q  <= '0;
        sum_q    <= '0;
        slot_q   <= '0;
        count_q  <= '0;
      end else if (do_update) begin
        valid_q[cur_slot_q] <= 1'b1;
        sum_q               <= sum_d;
        slot_q              <= (next_ext >= eff_win) ? '0 : raf_pkg::SLOT_W'(next_ext);
        count_q             <= count_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_slot_q <= cur_slot;
      sample_q   <= sample_i;
    end
    if (load_out) begin
      average_q <= quotient;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

  // fill count never passes the effective window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= eff_win)
    else $error("fill count above window");

  // write slot stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_ext < eff_win)
    else $error("write slot outside window");

  // an empty window holds a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("nonzero sum with empty window");

  // an accepted item goes straight to the sum update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == raf_pkg::S_UPDATE))
    else $error("accepted item skipped the update");

  // divider never finishes outside the divide state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == raf_pkg::S_DIVIDE))
    else $error("divider done outside divide state");

endmodule

FILE: tb/running_average_filter_test.sv
// ----------------------------------------------------------------------------
// running_average_filter_test
// self-checking bench for the boxcar running average filter: a small
// scoreboard keeps its own ring, sum and fill count, predicts each average
// and compares it with what the block puts out; directed corner items come
// first, then phases of random windows and samples with random idling on
// both sides and a long output hold-off that backs up the input
// ----------------------------------------------------------------------------
module running_average_filter_test;

  typedef logic signed [raf_pkg::DATA_W-1:0] sample_t;

  // run length and limits
  localparam int unsigned SAMPLE_TARGET = 1250;
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with nothing moving
  localparam int unsigned HOLD_OFF      = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 60;    // a bit over one item latency
  localparam logic [raf_pkg::WIN_W-1:0] WIN_TOP = '1;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the ring and running sum, queue of averages due
  // --------------------------------------------------------------------------
  class window_average_board;
    sample_t     ring [raf_pkg::MAX_WINDOW];
    longint      running_sum;
    int unsigned next_slot;
    int unsigned fill_count;
    int unsigned eff_window;
    sample_t     expected_averages [$];
    int unsigned mismatches;
    int unsigned averages_checked;

    function new();
      mismatches       = 0;
      averages_checked = 0;
      set_window(raf_pkg::WINDOW_RESET);
    endfunction

    // any window write also empties the ring and restarts warm-up
    function void set_window(logic [raf_pkg::WIN_W-1:0] value);
      if (value == '0) begin
        eff_window = 1;
      end else if (value > raf_pkg::MAX_WINDOW) begin
        eff_window = raf_pkg::MAX_WINDOW;
      end else begin
        eff_window = 32'(value);
      end
      foreach (ring[i]) ring[i] = '0;
      running_sum = 0;
      next_slot   = 0;
      fill_count  = 0;
    endfunction

    function int unsigned pending();
      return expected_averages.size();
    endfunction

    // accepted input item: replace oldest entry, update sum, queue the average
    function void note_sample(sample_t value);
      longint quotient;
      if (next_slot >= eff_window) next_slot = 0;
      running_sum = running_sum - ring[next_slot] + value;
      ring[next_slot] = value;
      next_slot = (next_slot + 1 >= eff_window) ? 0 : next_slot + 1;
      if (fill_count < eff_window) fill_count++;
      // signed 64-bit division truncates toward zero
      quotient = running_sum / longint'(fill_count);
      expected_averages.push_back(sample_t'(quotient));
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    // accepted result item: compare with the oldest average due
    task check_average(sample_t got);
      sample_t want;
      if (expected_averages.size() == 0) begin
        report($sformatf("average %0d came out with no sample waiting", got));
      end else begin
        want = expected_averages.pop_front();
        averages_checked++;
        if (got !== want) begin
          report($sformatf("average #%0d is %0d (0x%08h), expected %0d (0x%08h)",
                           averages_checked, got, got, want, want));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                      clk_i;
  logic                      rst_ni           = 1'b0;
  logic                      window_size_we_i = 1'b0;
  logic [raf_pkg::WIN_W-1:0] window_size_i    = raf_pkg::WINDOW_RESET;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  sample_t                   sample_i         = '0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  sample_t                   average_o;

  running_average_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .average_o        (average_o)
  );

  window_average_board sb = new();

  // idling switches, hold-off request and run statistics
  bit          send_idle_on    = 1'b1;
  bit          recv_idle_on    = 1'b1;
  int unsigned hold_cycles     = 0;
  int unsigned samples_sent    = 0;
  int unsigned windows_written = 0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // driving tasks and random item makers
  // --------------------------------------------------------------------------

  // offer one item, keep it steady while stalled, note it once accepted
  task automatic send_sample(input sample_t value);
    while (send_idle_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_sample(value);
    samples_sent++;
  endtask

  // window writes only with the block empty: every item yields one result,
  // so an empty scoreboard means nothing is left inside
  task automatic write_window(input logic [raf_pkg::WIN_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
    window_size_we_i <= 1'b1;
    window_size_i    <= value;
    @(posedge clk_i);
    sb.set_window(value);
    window_size_we_i <= 1'b0;
    windows_written++;
  endtask

  // corners of the register (zero and above-maximum included) or random
  function automatic logic [raf_pkg::WIN_W-1:0] pick_window();
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll == 0) begin
      case ($urandom_range(6))
        0:       return '0;
        1:       return raf_pkg::WIN_W'(1);
        2:       return raf_pkg::WIN_W'(2);
        3:       return raf_pkg::WIN_W'(raf_pkg::MAX_WINDOW - 1);
        4:       return raf_pkg::WIN_W'(raf_pkg::MAX_WINDOW);
        5:       return raf_pkg::WIN_W'(raf_pkg::MAX_WINDOW + 1);
        default: return WIN_TOP;
      endcase
    end else if (roll == 1 || roll == 2) begin
      return raf_pkg::WIN_W'($urandom_range(raf_pkg::MAX_WINDOW, 1));
    end
    return raf_pkg::WIN_W'($urandom_range(WIN_TOP, 0));
  endfunction

  // full range, extremes, small values around zero, near-extreme values
  function automatic sample_t pick_sample();
    int unsigned roll;
    roll = $urandom_range(19);
    if (roll < 8) begin
      return sample_t'($urandom);
    end else if (roll < 12) begin
      case ($urandom_range(6))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh8000_0001;
        3:       return 32'sh7FFF_FFFE;
        4:       return '0;
        5:       return 32'sh0000_0001;
        default: return '1;
      endcase
    end else if (roll < 17) begin
      return sample_t'(int'($urandom_range(200)) - 100);
    end
    if ($urandom_range(1) == 0) return sample_t'(32'h8000_0000 | $urandom_range(4095));
    return sample_t'(32'h7FFF_F000 | $urandom_range(4095));
  endfunction

  // --------------------------------------------------------------------------
  // result side: stall at random, or for a long stretch on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= recv_idle_on && ($urandom_range(99) < 28);
      end
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      sb.check_average(average_o);
    end
  end

  // ends the run if nothing moves for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
          window_size_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_len;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window of 20: extremes, sum carrying past 32 bits, sign flips
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    send_sample('0);
    send_sample('1);
    send_sample(32'sh0000_0001);

    // window of 2: -3 then 0 averages to -1 (truncation toward zero),
    // then a rewrite of the same value must empty the ring
    write_window(raf_pkg::WIN_W'(2));
    send_sample(-32'sd3);
    send_sample('0);
    send_sample(32'sd5);
    write_window(raf_pkg::WIN_W'(2));
    send_sample(32'sd7);

    // zero window behaves as a window of one
    write_window('0);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'shAAAA_AAAA);

    // all-ones window is clamped to the deepest ring
    write_window(WIN_TOP);
    send_sample(32'sh5555_5555);
    send_sample(-32'sd7);

    write_window(raf_pkg::WIN_W'(1));
    send_sample(32'sh1234_5678);

    write_window(raf_pkg::WIN_W'(raf_pkg::MAX_WINDOW));
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);

    // random phases, each with a fresh window; phases 4..7 run without
    // idling on either side, phases 2 and 11 get the long output hold-off
    phase = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      write_window(pick_window());
      send_idle_on = !(phase >= 4 && phase < 8);
      recv_idle_on = send_idle_on;
      if (phase == 2 || phase == 11) hold_cycles = HOLD_OFF;
      phase_len = $urandom_range(70, 8);
      repeat (phase_len) send_sample(pick_sample());
      phase++;
    end
    in_valid_i <= 1'b0;

    // drain, then give the block time to show any stray result
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d samples under %0d window writes, %0d averages compared",
             samples_sent, windows_written, sb.averages_checked);
    $display("windows of zero, one, the maximum and above it were used, and the output"
             , " was held off long enough to back up the input");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
